/* rtl/assert_macros.svh */
// Assertion helpers, clocked on clk_i and disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be true at a clock edge out of reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

/* rtl/ssna_pkg.sv */
package ssna_pkg;

  localparam logic [7:0] NEWLINE    = 8'h0A;
  localparam int         CFG_DW     = 64;
  localparam int         PAT_WORDS  = 4;
  localparam int         WORD_BYTES = 8;
  localparam int         PAT_BYTES  = PAT_WORDS * WORD_BYTES;

  typedef enum logic [2:0] {
    CFG_LENGTH = 3'd0,
    CFG_WORD0  = 3'd1,
    CFG_WORD1  = 3'd2,
    CFG_WORD2  = 3'd3,
    CFG_WORD3  = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       has_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic        found;
    logic [15:0] position;
    logic        overflow;
  } out_t;

  // control shared by every cell of the chain
  typedef struct packed {
    logic shift;
    logic clear;
  } ssna_ctl_t;

endpackage

/* rtl/ssna_cell.sv */
module ssna_cell import ssna_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ssna_ctl_t  ctl_i,
  input  logic [7:0] text_byte_i,
  input  logic [7:0] pat_byte_i,
  input  logic       prev_i,
  output logic       hit_o,
  output logic       match_o
);

  logic match_q;

  // prefix up to this cell matches ending at the incoming byte
  assign hit_o   = prev_i && (text_byte_i == pat_byte_i);
  assign match_o = match_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else if (ctl_i.clear) begin
      match_q <= 1'b0;
    end else if (ctl_i.shift) begin
      match_q <= hit_o;
    end
  end

endmodule

/* rtl/substring_search_newline_anchor.sv */
// Streaming substring search: takes one text byte per cycle unless a held result waits on
// out_ready_i, and returns one result request in the cycle after the last item of a text
// area is taken. The rate is set by the chain of MAX_PATTERN match cells, each comparing
// the byte with its own pattern byte and passing its prefix-match flag on per taken byte;
// the start of text check for a pattern that opens with a newline runs beside the chain.
`include "assert_macros.svh"

module substring_search_newline_anchor import ssna_pkg::*; #(
  parameter int MAX_PATTERN = 32,
  parameter int MAX_TEXT    = 65536
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_t               in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_t              out_data_o,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [CFG_DW-1:0] cfg_data_i
);

  localparam int LW    = $clog2(MAX_PATTERN + 1);
  localparam int IW    = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int Slots = 2 ** IW;
  localparam int CW    = $clog2(MAX_TEXT + MAX_PATTERN + 1);
  localparam int PW    = $clog2(MAX_TEXT);

  localparam logic [CW-1:0] CountCap = CW'(MAX_TEXT + MAX_PATTERN);
  localparam logic [CW-1:0] TextMax  = CW'(MAX_TEXT);
  localparam logic [CW:0]   PosMax   = (CW + 1)'(MAX_TEXT - 1);

  logic [5:0]                         pat_len_q;
  logic [PAT_WORDS-1:0][CFG_DW-1:0]   pat_words_q;
  logic [7:0]                         pat_b [Slots];
  logic [LW-1:0]                      len_used;
  logic [LW-1:0]                      lenm1;

  logic [CW-1:0] count_q, count_d;
  logic          seen_q, seen_d;
  logic [PW-1:0] pos_q, pos_d;
  logic          start_bad_q, start_bad_d;
  logic          first_nl_q, first_nl_d;
  logic          out_valid_q;
  out_t          out_data_q;

  logic          in_acc, take, close;
  logic          lead, eval, at_start, new_match, hit_sel;
  logic          start_cmp;
  logic [CW:0]   nxt, p1, pclamp;
  logic [CW-1:0] p;
  logic [PW-1:0] pos_new;
  out_t          res;

  logic [MAX_PATTERN-1:0] hits, pfx_match;
  ssna_ctl_t              ctl;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_len_q   <= '0;
      pat_words_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_LENGTH: pat_len_q      <= cfg_data_i[5:0];
        CFG_WORD0:  pat_words_q[0] <= cfg_data_i;
        CFG_WORD1:  pat_words_q[1] <= cfg_data_i;
        CFG_WORD2:  pat_words_q[2] <= cfg_data_i;
        CFG_WORD3:  pat_words_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pattern bytes beyond the configured words read as zero
  for (genvar k = 0; k < Slots; k++) begin : g_pat
    if (k < PAT_BYTES && k < MAX_PATTERN) begin : g_real
      assign pat_b[k] = pat_words_q[k / WORD_BYTES][(k % WORD_BYTES) * 8 +: 8];
    end else begin : g_zero
      assign pat_b[k] = 8'h00;
    end
  end

  always_comb begin
    if (pat_len_q > 6'(MAX_PATTERN)) begin
      len_used = LW'(MAX_PATTERN);
    end else begin
      len_used = LW'(pat_len_q);
    end
  end
  assign lenm1 = len_used - LW'(1);

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;
  assign take       = in_acc && in_data_i.has_byte;
  assign close      = in_acc && in_data_i.last_byte;

  assign ctl.shift = take;
  assign ctl.clear = close;

  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
    logic prev;
    if (j == 0) begin : g_first
      assign prev = 1'b1;
    end else begin : g_rest
      assign prev = pfx_match[j-1];
    end
    ssna_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .text_byte_i (in_data_i.text_byte),
      .pat_byte_i  (pat_b[j]),
      .prev_i      (prev),
      .hit_o       (hits[j]),
      .match_o     (pfx_match[j])
    );
  end

  assign lead    = (pat_b[0] == NEWLINE);
  assign hit_sel = hits[lenm1[IW-1:0]];

  always_comb begin
    count_d = count_q;
    if (take && count_q != CountCap) begin
      count_d = count_q + CW'(1);
    end

    // start of text: pattern byte i+1 against text byte i
    nxt         = {1'b0, count_q} + (CW + 1)'(1);
    start_cmp   = take && (nxt < (CW + 1)'(len_used));
    start_bad_d = start_bad_q;
    if (start_cmp && (in_data_i.text_byte != pat_b[nxt[IW-1:0]])) begin
      start_bad_d = 1'b1;
    end
    first_nl_d = first_nl_q;
    if (take && count_q == '0) begin
      first_nl_d = (in_data_i.text_byte == NEWLINE);
    end

    eval      = take && !seen_q && (len_used != '0) && (count_d >= CW'(len_used));
    at_start  = lead && (count_d == CW'(len_used));
    new_match = at_start ? !start_bad_d : hit_sel;

    p      = count_d - CW'(len_used);
    p1     = {1'b0, p} + (CW + 1)'(lead);
    pclamp = (p1 > PosMax) ? PosMax : p1;
    pos_new = at_start ? PW'(first_nl_d) : PW'(pclamp);

    seen_d = seen_q;
    pos_d  = pos_q;
    if (eval && new_match) begin
      seen_d = 1'b1;
      pos_d  = pos_new;
    end

    res.found    = (len_used == '0) || seen_d;
    res.position = ((len_used != '0) && seen_d) ? 16'(pos_d) : 16'h0000;
    res.overflow = (count_d > TextMax);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      seen_q      <= 1'b0;
      pos_q       <= '0;
      start_bad_q <= 1'b0;
      first_nl_q  <= 1'b0;
    end else if (close) begin
      count_q     <= '0;
      seen_q      <= 1'b0;
      pos_q       <= '0;
      start_bad_q <= 1'b0;
      first_nl_q  <= 1'b0;
    end else if (take) begin
      count_q     <= count_d;
      seen_q      <= seen_d;
      pos_q       <= pos_d;
      start_bad_q <= start_bad_d;
      first_nl_q  <= first_nl_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (close) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (close) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `ASSERT_CLK(a_last_gives_result, close |=> out_valid_o, "last item gave no result")
  `ASSERT_CLK(a_result_from_last, $rose(out_valid_o) |-> $past(close), "result without last item")
  `ASSERT_NEVER(a_pos_when_missing, out_valid_o && !out_data_o.found && out_data_o.position != 16'h0000, "position set on miss")
  `ASSERT_CLK(a_first_match_kept, (seen_q && !close) |=> (seen_q && $stable(pos_q)), "earliest match lost")

endmodule
